### sv/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Used by the channel interfaces, the front, the queue and the back.
package tcw_pkg;

  // Fixed field widths
  localparam int KIND_W  = 2;
  localparam int CODE_W  = 8;
  localparam int POS_W   = 8;
  localparam int CELL_W  = 16;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int COLOR_W = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd1;
  localparam logic [COLOR_W-1:0]   FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0]   BG_RESET = 4'd0;

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SETPOS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  // Special character bytes
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
  localparam int TAB_STEP = 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Operation classes decided by the front
  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_NEWLINE = 3'd1,
    OP_TAB     = 3'd2,
    OP_SETPOS  = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              col_ok;
    logic              row_ok;
  } entry_t;

  // Back-engine states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_READ  = 3'b100
  } back_state_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

### sv/tcw_if.sv
// Valid/ready channel interfaces of the text console writer.
// Depends on tcw_pkg for field widths.
interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::KIND_W-1:0]   kind;
  logic [tcw_pkg::CODE_W-1:0]   char_code;
  logic [tcw_pkg::POS_W-1:0]    column;
  logic [tcw_pkg::POS_W-1:0]    row;

  modport source (output valid, kind, char_code, column, row, input ready);
  modport sink   (input valid, kind, char_code, column, row, output ready);
endinterface

interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CELL_W-1:0]   cell_value;
  logic [tcw_pkg::COL_W-1:0]    cursor_column;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;

  modport source (output valid, cell_value, cursor_column, cursor_row, input ready);
  modport sink   (input valid, cell_value, cursor_column, cursor_row, output ready);
endinterface

### sv/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/tcw_front.sv
// Front of the text console writer: accepts input items and classifies them.
// Depends on tcw_pkg and tcw_if.
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  tcw_in_if.sink                in_ch,
  input  tcw_pkg::back_status_t status,
  input  logic                  q_full,
  output logic                  push,
  output tcw_pkg::entry_t       push_entry
);

  // Accept only when the queue has room and the startup clear is done
  assign in_ch.ready = !q_full && !status.init_busy;
  assign push        = in_ch.valid && in_ch.ready;

  // Classify the item and judge the coordinates against the screen size
  always_comb begin
    push_entry        = '0;
    push_entry.code   = in_ch.char_code;
    push_entry.column = in_ch.column;
    push_entry.row    = in_ch.row;
    push_entry.col_ok = in_ch.column < tcw_pkg::POS_W'(COLUMNS);
    push_entry.row_ok = in_ch.row < tcw_pkg::POS_W'(ROWS);
    case (in_ch.kind)
      tcw_pkg::KIND_PUT: begin
        if (in_ch.char_code == tcw_pkg::CODE_NEWLINE) begin
          push_entry.op = tcw_pkg::OP_NEWLINE;
        end else if (in_ch.char_code == tcw_pkg::CODE_TAB) begin
          push_entry.op = tcw_pkg::OP_TAB;
        end else begin
          push_entry.op = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::KIND_SETPOS: push_entry.op = tcw_pkg::OP_SETPOS;
      tcw_pkg::KIND_CLEAR:  push_entry.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::KIND_READ:   push_entry.op = tcw_pkg::OP_READ;
      default:              push_entry.op = tcw_pkg::OP_READ;
    endcase
  end

endmodule

### sv/tcw_queue.sv
// Short queue of classified items between the front and the back.
// Depends on tcw_pkg.
module tcw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcw_pkg::entry_t push_entry,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop_ready,
  output tcw_pkg::entry_t pop_entry
);

  tcw_pkg::entry_t                 slots [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]      wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]      rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]      count;
  logic                            pop;

  assign full      = count == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop       = pop_valid && pop_ready;
  assign pop_entry = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue push while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH)) else $error("queue count out of range");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1) else $error("queue pop lost");

endmodule

### sv/tcw_back.sv
// Back of the text console writer: cursor, scroll ring, cell store sweeps
// and the result register. Depends on tcw_pkg, tcw_if and tcw_ram.
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  tcw_pkg::entry_t               q_entry,
  input  logic [tcw_pkg::COLOR_W-1:0]   fg_color,
  input  logic [tcw_pkg::COLOR_W-1:0]   bg_color,
  output tcw_pkg::back_status_t         status,
  tcw_out_if.source                     out_ch
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = tcw_pkg::COL_W;
  localparam int RW    = tcw_pkg::ROW_W;
  localparam int PW    = tcw_pkg::POS_W;

  tcw_pkg::back_state_t state;
  logic [CW-1:0]  cur_col;
  logic [RW-1:0]  cur_row;
  logic [RW-1:0]  base;
  logic [AW-1:0]  sweep_addr;
  logic [AW-1:0]  sweep_last;
  logic           sweep_emit;
  logic           init_done;
  logic           out_valid;
  logic [tcw_pkg::CELL_W-1:0] out_cell;
  logic [CW-1:0]  out_col;
  logic [RW-1:0]  out_row;

  logic [CW-1:0]  cur_col_next;
  logic [RW-1:0]  cur_row_next;
  logic [RW-1:0]  base_next;
  logic           take;
  logic           slot_free;
  logic           out_set;
  logic           do_scroll;
  logic           do_clear;
  logic           do_read;
  logic [PW-1:0]  tab_next;
  logic [AW-1:0]  cur_addr;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  scroll_start;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  // Map a logical row through the scroll ring to a cell address
  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] lrow, logic [CW-1:0] lcol,
                                               logic [RW-1:0] ring_base);
    logic [RW:0] sum;
    logic [RW:0] prow;
    sum  = {1'b0, lrow} + {1'b0, ring_base};
    prow = (sum >= (RW+1)'(ROWS)) ? sum - (RW+1)'(ROWS) : sum;
    return AW'(prow) * AW'(COLUMNS) + AW'(lcol);
  endfunction

  assign status.init_busy = !init_done;
  assign slot_free        = !out_valid || out_ch.ready;
  assign take             = (state == tcw_pkg::S_IDLE) && q_valid && slot_free && init_done;
  assign q_ready          = take;

  assign cur_addr     = cell_addr(cur_row, cur_col, base);
  assign rd_addr      = cell_addr(q_entry.row[RW-1:0], q_entry.column[CW-1:0], base);
  assign scroll_start = AW'(base) * AW'(COLUMNS);
  assign tab_next     = PW'({1'b0, cur_col & ~CW'(tcw_pkg::TAB_STEP - 1)})
                        + PW'(tcw_pkg::TAB_STEP);

  // Work out the cursor move of the item at the head of the queue
  always_comb begin
    logic newline;
    newline      = 1'b0;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    base_next    = base;
    do_scroll    = 1'b0;
    do_clear     = 1'b0;
    do_read      = 1'b0;
    case (q_entry.op)
      tcw_pkg::OP_PUT: begin
        if (cur_col == CW'(COLUMNS - 1)) begin
          newline = 1'b1;
        end else begin
          cur_col_next = cur_col + 1'b1;
        end
      end
      tcw_pkg::OP_NEWLINE: newline = 1'b1;
      tcw_pkg::OP_TAB: begin
        if (tab_next >= PW'(COLUMNS)) begin
          newline = 1'b1;
        end else begin
          cur_col_next = tab_next[CW-1:0];
        end
      end
      tcw_pkg::OP_SETPOS: begin
        if (q_entry.col_ok) begin
          cur_col_next = q_entry.column[CW-1:0];
        end
        if (q_entry.row_ok) begin
          cur_row_next = q_entry.row[RW-1:0];
        end
      end
      tcw_pkg::OP_CLEAR: begin
        do_clear     = 1'b1;
        cur_col_next = '0;
        cur_row_next = '0;
        base_next    = '0;
      end
      tcw_pkg::OP_READ: do_read = q_entry.col_ok && q_entry.row_ok;
      default: ;
    endcase
    // Next line: scroll the ring when already on the last row
    if (newline) begin
      cur_col_next = '0;
      if (cur_row == RW'(ROWS - 1)) begin
        do_scroll = 1'b1;
        base_next = (base == RW'(ROWS - 1)) ? '0 : base + 1'b1;
      end else begin
        cur_row_next = cur_row + 1'b1;
      end
    end
  end

  // Drive the write port: blanking sweep or a character cell
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {bg_color, fg_color, q_entry.code};
    if (state == tcw_pkg::S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else if (take && q_entry.op == tcw_pkg::OP_PUT) begin
      ram_we = 1'b1;
    end
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (take && do_read),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Flag the edges that load a finished result
  assign out_set = (take && !do_clear && !do_scroll && !do_read)
                   || (state == tcw_pkg::S_SWEEP && sweep_emit && sweep_addr == sweep_last)
                   || (state == tcw_pkg::S_READ);

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_set) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequence the back: take items, sweep the store, collect read data
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::S_SWEEP;
      cur_col    <= '0;
      cur_row    <= '0;
      base       <= '0;
      sweep_addr <= '0;
      sweep_last <= AW'(CELLS - 1);
      sweep_emit <= 1'b0;
      init_done  <= 1'b0;
    end else begin
      case (state)
        tcw_pkg::S_IDLE: begin
          if (take) begin
            cur_col  <= cur_col_next;
            cur_row  <= cur_row_next;
            base     <= base_next;
            out_cell <= '0;
            out_col  <= cur_col_next;
            out_row  <= cur_row_next;
            if (do_clear) begin
              state      <= tcw_pkg::S_SWEEP;
              sweep_addr <= '0;
              sweep_last <= AW'(CELLS - 1);
              sweep_emit <= 1'b1;
            end else if (do_scroll) begin
              state      <= tcw_pkg::S_SWEEP;
              sweep_addr <= scroll_start;
              sweep_last <= scroll_start + AW'(COLUMNS - 1);
              sweep_emit <= 1'b1;
            end else if (do_read) begin
              state <= tcw_pkg::S_READ;
            end
          end
        end
        tcw_pkg::S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == sweep_last) begin
            state     <= tcw_pkg::S_IDLE;
            init_done <= 1'b1;
          end
        end
        tcw_pkg::S_READ: begin
          state    <= tcw_pkg::S_IDLE;
          out_cell <= ram_rdata;
        end
        default: state <= tcw_pkg::S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.cell_value    = out_cell;
  assign out_ch.cursor_column = out_col;
  assign out_ch.cursor_row    = out_row;

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cur_col < CW'(COLUMNS) && cur_row < RW'(ROWS) && base < RW'(ROWS))
    else $error("cursor or ring base out of range");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> (state == tcw_pkg::S_IDLE && init_done))
    else $error("item taken while busy");
  a_read_emits: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::S_READ) |=> out_valid)
    else $error("read result not presented");
  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    (take && do_scroll) |=> (state == tcw_pkg::S_SWEEP && cur_row == RW'(ROWS - 1)))
    else $error("scroll did not start a row sweep");

endmodule

### sv/text_console_writer.sv
// Text console writer top level: configuration registers and the
// front, queue and back. Depends on tcw_pkg, tcw_if, tcw_front, tcw_queue, tcw_back.
//
// Use: items enter on in_ch (kind, char_code, column, row) and every item
// gives exactly one result on out_ch (cell_value, cursor_column, cursor_row),
// in order. Both channels take an item when valid and ready are high at a
// rising edge of clk. Colors are written through cfg_we/cfg_index/cfg_data
// (index 0 foreground, index 1 background); the user must write them only
// while the block is idle; the block does not enforce it. Timing: put char,
// newline, tab, set position and out-of-range reads load the result register
// when the back accepts them; a cell read first passes S_READ for the
// registered store read. A line feed, or a wrapping put char or tab, on the
// bottom row blanks one row of the store before its result; clear blanks the
// whole store. The back takes one item per cycle while no sweep runs and the
// receiver does not stall, except in-range cell reads, which hold the single
// back engine in S_READ before the next. Reset: synchronous on rst; cursor
// to 0,0, colors to 7/0, then a clearing pass over all ROWS*COLUMNS cells
// (2000 by default) during which in_ch.ready stays low. A stalled receiver
// holds the result register; the queue then fills and in_ch.ready falls.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data,
  tcw_in_if.sink                            in_ch,
  tcw_out_if.source                         out_ch
);

  logic [tcw_pkg::COLOR_W-1:0] fg_color;
  logic [tcw_pkg::COLOR_W-1:0] bg_color;
  tcw_pkg::back_status_t       status;
  tcw_pkg::entry_t             push_entry;
  tcw_pkg::entry_t             q_entry;
  logic                        push;
  logic                        q_full;
  logic                        q_valid;
  logic                        q_ready;

  // Hold the color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= tcw_pkg::FG_RESET;
      bg_color <= tcw_pkg::BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_FOREGROUND: fg_color <= cfg_data;
        tcw_pkg::CFG_BACKGROUND: bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_ch      (in_ch),
    .status     (status),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry),
    .fg_color (fg_color),
    .bg_color (bg_color),
    .status   (status),
    .out_ch   (out_ch)
  );

endmodule
